>>> rtl/core/fct_pkg.sv
// Shared types and constants for the frustum cull test core.
package fct_pkg;

	localparam int unsigned COORD_W    = 20;  // signed Q11.8 coordinate
	localparam int unsigned EXT_W      = 19;  // unsigned Q11.8 extent
	localparam int unsigned COEF_W     = 14;  // signed Q1.12 a, b, c
	localparam int unsigned D_W        = 22;  // signed Q13.8 d
	localparam int unsigned FRAC_SHIFT = 12;  // aligns Q.8 terms to 2^-20
	localparam int unsigned PROD_W     = COEF_W + COORD_W;
	localparam int unsigned EPROD_W    = COEF_W + EXT_W;
	localparam int unsigned SUM_W      = 38;  // exact distance plus extent term
	localparam int unsigned REG_COUNT  = 6;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	typedef enum logic [1:0] {
		OP_POINT  = 2'd0,
		OP_CUBE   = 2'd1,
		OP_SPHERE = 2'd2,
		OP_BOX    = 2'd3
	} opcode_t;

	// Register layout: d in 63:42, c in 41:28, b in 27:14, a in 13:0
	typedef struct packed {
		logic signed [D_W-1:0]    d;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
	} plane_t;

	typedef struct packed {
		opcode_t                   op;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic [EXT_W-1:0]          ex;
		logic [EXT_W-1:0]          ey;
		logic [EXT_W-1:0]          ez;
	} volume_t;

endpackage

>>> rtl/core/fct_plane_regs.sv
// Plane coefficient register file written through the configuration port.
module fct_plane_regs import fct_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	output plane_t [REG_COUNT-1:0]        planes
);

	plane_t [REG_COUNT-1:0] plane_q;

	assign cfg_ready = 1'b1;
	assign planes    = plane_q;

	// writes past the last register are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
			plane_q[cfg_index] <= plane_t'(cfg_data);
		end
	end

endmodule

>>> rtl/core/fct_plane_eval.sv
// One plane lane: signed distance plus volume reach, rejects when negative.
module fct_plane_eval import fct_pkg::*; (
	input  plane_t  plane,
	input  volume_t vol,
	output logic    reject
);

	logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
	logic [COEF_W-1:0]        abs_a, abs_b, abs_c;
	logic [EXT_W-1:0]         ey_eff, ez_eff;
	logic [EPROD_W-1:0]       reach_x, reach_y, reach_z;
	logic signed [SUM_W-1:0]  plane_dist;
	logic signed [SUM_W-1:0]  reach;
	logic signed [SUM_W-1:0]  total;

	assign prod_x = plane.a * vol.cx;
	assign prod_y = plane.b * vol.cy;
	assign prod_z = plane.c * vol.cz;

	// -8192 maps to 8192, which still fits the unsigned width
	assign abs_a = plane.a[COEF_W-1] ? COEF_W'(-plane.a) : COEF_W'(plane.a);
	assign abs_b = plane.b[COEF_W-1] ? COEF_W'(-plane.b) : COEF_W'(plane.b);
	assign abs_c = plane.c[COEF_W-1] ? COEF_W'(-plane.c) : COEF_W'(plane.c);

	// a cube uses its single radius on every axis
	assign ey_eff = (vol.op == OP_CUBE) ? vol.ex : vol.ey;
	assign ez_eff = (vol.op == OP_CUBE) ? vol.ex : vol.ez;

	assign reach_x = abs_a * vol.ex;
	assign reach_y = abs_b * ey_eff;
	assign reach_z = abs_c * ez_eff;

	assign plane_dist = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z)
		+ (SUM_W'(plane.d) <<< FRAC_SHIFT);

	always_comb begin
		unique case (vol.op)
			OP_POINT:  reach = '0;
			OP_SPHERE: reach = $signed(SUM_W'(vol.ex) << FRAC_SHIFT);
			OP_CUBE,
			OP_BOX:    reach = $signed(SUM_W'(reach_x)) + $signed(SUM_W'(reach_y))
				+ $signed(SUM_W'(reach_z));
			default:   reach = '0;
		endcase
	end

	// farthest corner (or sphere edge) still behind the plane
	assign total  = plane_dist + reach;
	assign reject = total[SUM_W-1];

endmodule

>>> rtl/core/frustum_cull_test_core.sv
// Frustum cull test core: tests bounding volumes against the frustum planes.
//
// Usage: software writes the six plane registers (near, far, left, right, top,
// bottom) on the cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) while no
// request is in flight. cfg_ready is always high; an index past the last
// register is dropped. Volumes arrive on the input channel (in_valid/in_stall)
// with opcode, center and extents; each request yields one visible result on the
// output channel (out_valid/out_stall).
// Pipeline: a taken request waits in the input register and its verdict is
// registered in the result register. Throughput is one request per cycle
// while the output is not stalled; all plane lanes run in parallel between the
// input register and the result register, so the lane's multiply-add path sets the clock.
// Reset clears both pipeline stages and sets every plane to zero, so every volume
// is visible until planes are written. When out_stall holds, the result stays put
// and an empty input register still takes one more request before in_stall rises.
module frustum_cull_test_core import fct_pkg::*; #(
	parameter int unsigned PLANE_COUNT = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic signed [COORD_W-1:0]   center_x,
	input  logic signed [COORD_W-1:0]   center_y,
	input  logic signed [COORD_W-1:0]   center_z,
	input  logic [EXT_W-1:0]            extent_x,
	input  logic [EXT_W-1:0]            extent_y,
	input  logic [EXT_W-1:0]            extent_z,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        visible
);

	// planes beyond the register count get no lane and never reject
	localparam int unsigned ACTIVE = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;

	plane_t [REG_COUNT-1:0] planes;
	volume_t                vol_d;
	volume_t                vol_s1;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   visible_s2;
	logic                   load_s1;
	logic                   load_s2;
	logic [ACTIVE-1:0]      reject;

	fct_plane_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	assign vol_d.op = opcode_t'(opcode);
	assign vol_d.cx = center_x;
	assign vol_d.cy = center_y;
	assign vol_d.cz = center_z;
	assign vol_d.ex = extent_x;
	assign vol_d.ey = extent_y;
	assign vol_d.ez = extent_z;

	assign load_s2  = !(valid_s2 && out_stall);
	assign in_stall = valid_s1 && !load_s2;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s2 || !valid_s1) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			vol_s1 <= vol_d;
		end
	end

	for (genvar i = 0; i < ACTIVE; i++) begin : g_lane
		fct_plane_eval u_lane (
			.plane  (planes[i]),
			.vol    (vol_s1),
			.reject (reject[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && valid_s1) begin
			visible_s2 <= ~|reject;
		end
	end

	assign out_valid = valid_s2;
	assign visible   = visible_s2;

	// a request in the input register moves on whenever the output can take it
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_s2 |=> valid_s2)
		else $error("request in input register did not advance");

	// a full pipeline under stall keeps its queued request
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |=> valid_s1)
		else $error("queued request lost while output stalled");

	// cleared planes reject nothing
	a_zero_visible: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_s2 && (planes == '0) |=> visible_s2)
		else $error("volume rejected by all-zero planes");

	// out-of-range config writes leave the planes alone
	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index >= CFG_IDX_W'(REG_COUNT)) |=> $stable(planes))
		else $error("plane changed by write past last register");

endmodule

>>> test/tb_frustum_cull_test_core.sv
// Self-checking testbench for the frustum cull test core.
`timescale 1ns / 1ps

module tb_frustum_cull_test_core import fct_pkg::*; ();

	localparam int unsigned PLANES      = 6;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned RAND_PHASES = 9;
	localparam int unsigned PHASE_ITEMS = 139;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  visible;
	volume_t               drv_item = '0;

	volume_t     pending_volumes[$];
	bit          visible_expected[$];
	plane_t      cull_planes[REG_COUNT];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned fail_count = 0;
	int unsigned quiet_cycles = 0;

	frustum_cull_test_core #(.PLANE_COUNT(PLANES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(drv_item.op),
		.center_x(drv_item.cx),
		.center_y(drv_item.cy),
		.center_z(drv_item.cz),
		.extent_x(drv_item.ex),
		.extent_y(drv_item.ey),
		.extent_z(drv_item.ez),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.visible(visible)
	);

	always #10 clk = ~clk;

	function automatic bit predict_visible(volume_t v);
		longint cx, cy, cz, ex, ey, ez, a, b, c, d, plane_dist;
		bit reject;
		cx = longint'(v.cx);
		cy = longint'(v.cy);
		cz = longint'(v.cz);
		ex = longint'(v.ex);
		ey = longint'(v.ey);
		ez = longint'(v.ez);
		if (v.op == OP_CUBE) begin
			ey = ex;
			ez = ex;
		end
		// planes past the register file are not evaluated and never reject
		for (int i = 0; i < PLANES && i < REG_COUNT; i++) begin
			a = longint'(cull_planes[i].a);
			b = longint'(cull_planes[i].b);
			c = longint'(cull_planes[i].c);
			d = longint'(cull_planes[i].d);
			plane_dist = a * cx + b * cy + c * cz + (d <<< FRAC_SHIFT);
			case (v.op)
				OP_POINT: begin
					reject = plane_dist < 0;
				end
				OP_SPHERE: begin
					reject = plane_dist < -(ex <<< FRAC_SHIFT);
				end
				default: begin
					// farthest corner along the plane normal
					reject = plane_dist + (a < 0 ? -a : a) * ex + (b < 0 ? -b : b) * ey
						+ (c < 0 ? -c : c) * ez < 0;
				end
			endcase
			if (reject)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic plane_t make_plane(int a, int b, int c, int d);
		plane_t p;
		p.a = a[COEF_W-1:0];
		p.b = b[COEF_W-1:0];
		p.c = c[COEF_W-1:0];
		p.d = d[D_W-1:0];
		return p;
	endfunction

	function automatic int pick_extreme(int unsigned w);
		case ($urandom_range(3))
			0: return -(1 << (w - 1));
			1: return (1 << (w - 1)) - 1;
			2: return 0;
			default: return int'($urandom);
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord(int unsigned scale);
		int r;
		r = int'($urandom_range(2 * scale)) - int'(scale);
		return r[COORD_W-1:0];
	endfunction

	function automatic volume_t rand_volume(int unsigned scale, bit wide);
		volume_t v;
		v.op = opcode_t'($urandom_range(3));
		if (wide || $urandom_range(7) == 0) begin
			v.cx = COORD_W'($urandom);
			v.cy = COORD_W'($urandom);
			v.cz = COORD_W'($urandom);
			v.ex = EXT_W'($urandom);
			v.ey = EXT_W'($urandom);
			v.ez = EXT_W'($urandom);
		end else begin
			v.cx = rand_coord(scale);
			v.cy = rand_coord(scale);
			v.cz = rand_coord(scale);
			v.ex = EXT_W'($urandom_range(scale / 2));
			v.ey = EXT_W'($urandom_range(scale / 2));
			v.ez = EXT_W'($urandom_range(scale / 2));
		end
		return v;
	endfunction

	task automatic queue_volume(opcode_t op, int cx, int cy, int cz, int ex, int ey, int ez);
		volume_t v;
		v.op = op;
		v.cx = cx[COORD_W-1:0];
		v.cy = cy[COORD_W-1:0];
		v.cz = cz[COORD_W-1:0];
		v.ex = ex[EXT_W-1:0];
		v.ey = ey[EXT_W-1:0];
		v.ez = ez[EXT_W-1:0];
		pending_volumes.push_back(v);
	endtask

	task automatic write_plane(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx < REG_COUNT)
			cull_planes[idx] = val;
	endtask

	// wait until every request is through and the pipeline is empty
	task automatic drain();
		while (pending_volumes.size() != 0 || in_valid || visible_expected.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				visible_expected.push_back(predict_visible(drv_item));
			if (!in_valid || !in_stall) begin
				if (pending_volumes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item <= pending_volumes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (visible_expected.size() == 0) begin
					$error("visible: no request pending, actual %0b", visible);
					fail_count++;
				end else begin
					bit want;
					want = visible_expected.pop_front();
					if (visible !== want) begin
						$error("visible: expected %0b, actual %0b", want, visible);
						fail_count++;
					end
				end
			end
			out_stall <= $urandom_range(99) < recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		int unsigned dmax, scale;
		int n;
		int coef[3];
		for (int i = 0; i < REG_COUNT; i++)
			cull_planes[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 14;
		recv_idle_pct = 81;

		// planes still at reset: everything is visible
		queue_volume(OP_POINT, 524287, 524287, 524287, 0, 0, 0);
		queue_volume(OP_CUBE, -524288, -524288, -524288, 524287, 0, 0);
		queue_volume(OP_SPHERE, -524288, 524287, 0, 524287, 524287, 524287);
		queue_volume(OP_BOX, 524287, -524288, 524287, 524287, 524287, 524287);
		queue_volume(OP_BOX, 0, 0, 0, 0, 0, 0);
		drain();

		// axis-aligned box of half-size 100.0; writes past the last index are dropped
		write_plane(0, make_plane(4096, 0, 0, 25600));
		write_plane(1, make_plane(-4096, 0, 0, 25600));
		write_plane(2, make_plane(0, 4096, 0, 25600));
		write_plane(3, make_plane(0, -4096, 0, 25600));
		write_plane(4, make_plane(0, 0, -4096, 25600));
		write_plane(5, make_plane(0, 0, 4096, 25600));
		write_plane(6, {$urandom, $urandom});
		write_plane(7, {$urandom, $urandom});
		queue_volume(OP_POINT, -25600, 0, 0, 0, 0, 0);
		queue_volume(OP_POINT, -25601, 0, 0, 0, 0, 0);
		queue_volume(OP_POINT, 25600, 25600, -25600, 0, 0, 0);
		queue_volume(OP_POINT, 0, 25601, 0, 0, 0, 0);
		queue_volume(OP_SPHERE, -25900, 0, 0, 300, 0, 0);
		queue_volume(OP_SPHERE, -25901, 0, 0, 300, 0, 0);
		queue_volume(OP_CUBE, -26100, 0, 0, 500, 0, 0);
		queue_volume(OP_CUBE, -26101, 0, 0, 500, 0, 0);
		queue_volume(OP_BOX, 0, 26300, 0, 0, 700, 0);
		queue_volume(OP_BOX, 0, 26301, 0, 0, 700, 0);
		queue_volume(OP_BOX, 0, 0, 0, 524287, 524287, 524287);
		drain();

		// coefficient extremes against coordinate extremes
		write_plane(0, make_plane(-8192, -8192, -8192, -(1 << 21)));
		write_plane(1, make_plane(8191, 8191, 8191, (1 << 21) - 1));
		write_plane(2, make_plane(8191, -8192, 0, 0));
		write_plane(3, make_plane(0, 0, 0, (1 << 21) - 1));
		write_plane(4, make_plane(-8192, 0, 8191, -(1 << 21)));
		write_plane(5, make_plane(0, 0, 0, 0));
		queue_volume(OP_POINT, -524288, -524288, -524288, 0, 0, 0);
		queue_volume(OP_POINT, 524287, 524287, 524287, 0, 0, 0);
		queue_volume(OP_SPHERE, 0, 0, 0, 524287, 0, 0);
		queue_volume(OP_CUBE, -524288, 524287, -524288, 524287, 0, 0);
		queue_volume(OP_BOX, 524287, 524287, 524287, 524287, 524287, 524287);
		queue_volume(OP_BOX, -524288, -524288, -524288, 524287, 524287, 524287);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph < 3) begin
				send_idle_pct = 14;
				recv_idle_pct = 81;
			end else if (ph < 6) begin
				send_idle_pct = 81;
				recv_idle_pct = 14;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			scale = 524287;
			case (ph % 3)
				0: begin
					// closed box with slightly tilted faces, volumes around it
					dmax = $urandom_range(1024, 200000);
					scale = (2 * dmax > 524287) ? 524287 : 2 * dmax;
					for (int i = 0; i < REG_COUNT; i++) begin
						n = int'($urandom_range(2048, 8191));
						if (i % 2)
							n = -n;
						for (int k = 0; k < 3; k++)
							coef[k] = int'($urandom_range(128)) - 64;
						coef[i / 2] = n;
						write_plane(CFG_IDX_W'(i), make_plane(coef[0], coef[1], coef[2],
							int'($urandom_range(dmax / 2, dmax))));
					end
				end
				1: begin
					// sparse random planes; zero planes never reject
					for (int i = 0; i < REG_COUNT; i++)
						write_plane(CFG_IDX_W'(i),
							$urandom_range(1) ? {$urandom, $urandom} : '0);
					write_plane(CFG_IDX_W'($urandom_range(REG_COUNT, 7)), {$urandom, $urandom});
				end
				default: begin
					for (int i = 0; i < REG_COUNT; i++)
						write_plane(CFG_IDX_W'(i), make_plane(pick_extreme(COEF_W),
							pick_extreme(COEF_W), pick_extreme(COEF_W), pick_extreme(D_W)));
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++)
				pending_volumes.push_back(rand_volume(scale, (ph % 3 != 0) && $urandom_range(1)));
			drain();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && visible_expected.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/fct_pkg.sv
rtl/core/fct_plane_regs.sv
rtl/core/fct_plane_eval.sv
rtl/core/frustum_cull_test_core.sv
test/tb_frustum_cull_test_core.sv
